// ===== rtl/frustum_cull_test_macros.svh =====
// assertion macros shared by the frustum cull checker
`ifndef FRUSTUM_CULL_TEST_MACROS_SVH
`define FRUSTUM_CULL_TEST_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define FCT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frustum cull check failed");

// next-cycle implication, disabled while reset is low
`define FCT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frustum cull check failed");

`endif

// ===== rtl/fct_pkg.sv =====
// shared types and constants for the frustum cull test block
`timescale 1ns / 1ps
`default_nettype none

package fct_pkg;

    localparam int NUM_PLANES = 6;
    localparam int COORD_W    = 16;
    localparam int RAD_W      = 15;
    localparam int NORM_FRAC  = 14;
    localparam int PLANE_W    = 4 * COORD_W;
    localparam int CFG_IDX_W  = 3;
    localparam int PROD_W     = 2 * COORD_W;
    localparam int TERM_W     = COORD_W + NORM_FRAC;
    localparam int BIAS_W     = TERM_W + 1;
    localparam int ACC_W      = PROD_W + 2;
    localparam int LATENCY    = 3;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic [PLANE_W-1:0]        t_plane;

    typedef enum logic {
        ACT_BOX    = 1'b0,
        ACT_SPHERE = 1'b1
    } t_action;

    typedef struct packed {
        t_action          action;
        t_coord [2:0]     box_min;
        t_coord [2:0]     box_max;
        t_coord [2:0]     center;
        logic [RAD_W-1:0] radius;
    } t_item;

endpackage

`default_nettype wire

// ===== rtl/frustum_cull_test.sv =====
// Frustum cull test: box or sphere against six configured planes, one item per clock.
// Accepts one item every clock while start is high (busy only rises during reset).
// Each item returns exactly one visible bit, strobed by o_valid for a single cycle
// and produced through these registers in order after acceptance: input register, a registered
// product stage with three 16x16 multipliers per plane (18 in all), then the exact
// 34-bit sum and sign test of all planes into the result register. The receiver
// cannot stall, so results must be taken in the cycle they appear. Plane writes go
// through the write port and must only be made with no item in flight.
`timescale 1ns / 1ps
`default_nettype none

module frustum_cull_test (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    output logic                              o_busy,
    input  wire logic                         i_cfg_we,
    input  wire logic [fct_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [fct_pkg::PLANE_W-1:0]  i_cfg_data,
    input  wire logic                         i_action,
    input  wire logic signed [15:0]           i_box_min_x,
    input  wire logic signed [15:0]           i_box_min_y,
    input  wire logic signed [15:0]           i_box_min_z,
    input  wire logic signed [15:0]           i_box_max_x,
    input  wire logic signed [15:0]           i_box_max_y,
    input  wire logic signed [15:0]           i_box_max_z,
    input  wire logic signed [15:0]           i_center_x,
    input  wire logic signed [15:0]           i_center_y,
    input  wire logic signed [15:0]           i_center_z,
    input  wire logic [14:0]                  i_sphere_radius,
    output logic                              o_valid,
    output logic                              o_visible
);
    import fct_pkg::*;

    t_plane                r_plane [NUM_PLANES];
    t_item                 n_item;
    t_item                 r_item;
    logic                  accept;
    logic                  r_vld_in;
    logic                  r_vld_mul;
    logic                  r_vld_out;
    logic                  r_visible;
    logic [NUM_PLANES-1:0] pass;

    assign o_busy = ~i_rst_n;
    assign accept = i_start & ~o_busy;

    always_comb begin
        n_item.action     = t_action'(i_action);
        n_item.box_min[0] = i_box_min_x;
        n_item.box_min[1] = i_box_min_y;
        n_item.box_min[2] = i_box_min_z;
        n_item.box_max[0] = i_box_max_x;
        n_item.box_max[1] = i_box_max_y;
        n_item.box_max[2] = i_box_max_z;
        n_item.center[0]  = i_center_x;
        n_item.center[1]  = i_center_y;
        n_item.center[2]  = i_center_z;
        n_item.radius     = i_sphere_radius;
    end

    // plane registers; writes to indexes past the last plane are dropped
    always_ff @(posedge i_clk) begin
        for (int p = 0; p < NUM_PLANES; p++) begin
            if (!i_rst_n) begin
                r_plane[p] <= '0;
            end else if (i_cfg_we && i_cfg_idx == CFG_IDX_W'(p)) begin
                r_plane[p] <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_in  <= 1'b0;
            r_vld_mul <= 1'b0;
            r_vld_out <= 1'b0;
        end else begin
            r_vld_in  <= accept;
            r_vld_mul <= r_vld_in;
            r_vld_out <= r_vld_mul;
        end
    end

    for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
        fct_plane_unit u_plane (
            .i_clk   (i_clk),
            .i_plane (r_plane[p]),
            .i_item  (r_item),
            .o_pass  (pass[p])
        );
    end

    always_ff @(posedge i_clk) begin
        r_visible <= &pass;
    end

    assign o_valid   = r_vld_out;
    assign o_visible = r_visible;

endmodule

`default_nettype wire

// ===== rtl/fct_plane_unit.sv =====
// one frustum plane: operand select, products, then exact sum and sign test
`timescale 1ns / 1ps
`default_nettype none

module fct_plane_unit (
    input  wire logic           i_clk,
    input  wire fct_pkg::t_plane i_plane,
    input  wire fct_pkg::t_item  i_item,
    output logic                o_pass
);
    import fct_pkg::*;

    logic signed [COORD_W-1:0] norm_c [3];
    logic signed [COORD_W-1:0] opnd   [3];
    logic signed [PROD_W-1:0]  n_prod [3];
    logic signed [PROD_W-1:0]  r_prod [3];
    logic signed [COORD_W-1:0] offs;
    logic signed [TERM_W-1:0]  offs_term;
    logic signed [TERM_W-1:0]  rad_term;
    logic signed [BIAS_W-1:0]  n_bias;
    logic signed [BIAS_W-1:0]  r_bias;
    logic signed [ACC_W-1:0]   acc;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            norm_c[a] = $signed(i_plane[a*COORD_W +: COORD_W]);
            // positive vertex: a non-negative normal picks the max corner
            if (i_item.action == ACT_SPHERE) begin
                opnd[a] = $signed(i_item.center[a]);
            end else if (norm_c[a][COORD_W-1]) begin
                opnd[a] = $signed(i_item.box_min[a]);
            end else begin
                opnd[a] = $signed(i_item.box_max[a]);
            end
            n_prod[a] = PROD_W'(norm_c[a]) * PROD_W'(opnd[a]);
        end
        offs      = $signed(i_plane[3*COORD_W +: COORD_W]);
        offs_term = $signed({offs, {NORM_FRAC{1'b0}}});
        if (i_item.action == ACT_SPHERE) begin
            rad_term = $signed({1'b0, i_item.radius, {NORM_FRAC{1'b0}}});
        end else begin
            rad_term = '0;
        end
        n_bias = BIAS_W'(offs_term) + BIAS_W'(rad_term);
    end

    always_ff @(posedge i_clk) begin
        for (int a = 0; a < 3; a++) begin
            r_prod[a] <= n_prod[a];
        end
        r_bias <= n_bias;
    end

    always_comb begin
        acc = ACC_W'(r_prod[0]) + ACC_W'(r_prod[1]) + ACC_W'(r_prod[2]) + ACC_W'(r_bias);
        // zero distance counts as inside
        o_pass = ~acc[ACC_W-1];
    end

endmodule

`default_nettype wire

// ===== rtl/fct_checker.sv =====
// port-level checker for the frustum cull test block, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

`include "frustum_cull_test_macros.svh"

module fct_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_start,
    input wire logic i_busy,
    input wire logic i_valid
);
    import fct_pkg::*;

    // every accepted beat gets its result a fixed latency later
    `FCT_ASSERT_NOW(a_result_follows, i_clk, i_rst_n, i_start && !i_busy, ##LATENCY i_valid)
    // no result strobe without a matching accepted beat
    `FCT_ASSERT_NOW(a_no_spurious, i_clk, i_rst_n, i_valid, $past(i_start && !i_busy, LATENCY))
    // out of reset the block never holds off an item
    `FCT_ASSERT_NOW(a_never_busy, i_clk, i_rst_n, 1'b1, !i_busy)
    // nothing accepted means no strobe after the latency
    `FCT_ASSERT_NOW(a_idle_quiet, i_clk, i_rst_n, !(i_start && !i_busy), ##LATENCY !i_valid)

endmodule

bind frustum_cull_test fct_checker u_fct_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_start (i_start),
    .i_busy  (o_busy),
    .i_valid (o_valid)
);

`default_nettype wire
